FILE: design/us2cal_pkg.sv
// ----------------------------------------------------------------------------
// us2cal_pkg
// Types and constants for the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package us2cal_pkg;

    localparam int IN_W = 39;
    localparam logic signed [IN_W-1:0] SECS_LOW  = -39'sd62167219200;
    localparam logic signed [IN_W-1:0] SECS_HIGH = 39'sd253402300799;
    localparam int DAYS_1Y   = 365;
    localparam int DAYS_4Y   = 4 * DAYS_1Y + 1;
    localparam int DAYS_100Y = 25 * DAYS_4Y - 1;
    localparam int DAYS_400Y = 4 * DAYS_100Y + 1;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
    } t_cal;

    // cumulative days before each month, non-leap year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        case (m)
            4'd0:    return 9'd0;
            4'd1:    return 9'd31;
            4'd2:    return 9'd59;
            4'd3:    return 9'd90;
            4'd4:    return 9'd120;
            4'd5:    return 9'd151;
            4'd6:    return 9'd181;
            4'd7:    return 9'd212;
            4'd8:    return 9'd243;
            4'd9:    return 9'd273;
            4'd10:   return 9'd304;
            4'd11:   return 9'd334;
            default: return 9'd365;
        endcase
    endfunction

endpackage

FILE: design/us2cal_if.sv
// ----------------------------------------------------------------------------
// us2cal_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface us2cal_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/unix_seconds_to_calendar_top.sv
// Pipeline: 9 register stages, r1 to r9; a word accepted at one edge is offered from r9.
// One word per cycle when not stalled; a valid bit travels with the data through every stage.
// The stages advance together and hold as a block when the output stalls.
// Reset (i_rst_n low, synchronous) clears every valid bit; data regs are not reset.
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_top
// Converts signed Unix seconds to a proleptic Gregorian date and time.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_top (
    input logic i_clk,
    input logic i_rst_n,
    us2cal_if.sink   i_in,
    us2cal_if.source o_out
);
    import us2cal_pkg::*;

    localparam int NST = 9;

    // reciprocals: floor(x / d) = (x * ceil(2^k / d)) >> k over each input range
    localparam logic [31:0] RCP_675   = 32'd3257812231;   // k = 41
    localparam logic [22:0] RCP_7     = 23'd4793491;      // k = 25
    localparam logic [21:0] RCP_400Y  = 22'd3762951;      // k = 39
    localparam logic [18:0] RCP_3600  = 19'd298262;       // k = 30
    localparam logic [12:0] RCP_60    = 13'd4370;         // k = 18
    localparam logic [15:0] RCP_1461  = 16'd45934;        // k = 26

    // day offsets of centuries 1..3 inside a 400-year cycle (century 0 is leap)
    localparam logic [17:0] CENT1 = 18'(DAYS_100Y + 1);
    localparam logic [17:0] CENT2 = 18'(2 * DAYS_100Y + 1);
    localparam logic [17:0] CENT3 = 18'(3 * DAYS_100Y + 1);

    // global stall: the pipe advances only when the output register is free
    logic adv;
    logic [NST-1:0] r_vld;
    assign adv      = !r_vld[NST-1] || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    // ---- stage 1: saturate and shift to year-0 origin -----------------------
    logic signed [IN_W-1:0] n_s;
    logic [IN_W-1:0] r1_t;          // seconds since 0000-01-01, < 2^39
    always_comb begin
        n_s = i_in.data;
        if (n_s < SECS_LOW)  n_s = SECS_LOW;
        if (n_s > SECS_HIGH) n_s = SECS_HIGH;
    end
    always_ff @(posedge i_clk) begin
        if (adv) r1_t <= n_s - SECS_LOW;
    end

    // ---- stage 2: day number ---------------------------------------------------
    // t / 86400 = (t >> 7) / 675, exact by reciprocal over t < 2^39
    logic [63:0] day_prod;
    assign day_prod = 64'(r1_t[38:7]) * 64'(RCP_675);
    logic [21:0] r2_day;
    logic [16:0] r2_tl;             // low bits of t, enough for the remainder
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_day <= day_prod[62:41];
            r2_tl  <= r1_t[16:0];
        end
    end

    // ---- stage 3: seconds of day, weekday and 400-year quotients ---------------
    logic [31:0] day675;
    logic [9:0]  sod_hi;
    logic [21:0] wd_x;
    logic [44:0] wd_prod;
    logic [43:0] q400_prod;
    always_comb begin
        day675    = 32'(r2_day) * 32'd675;
        sod_hi    = r2_tl[16:7] - day675[9:0];   // remainder < 675
        wd_x      = r2_day + 22'd6;
        wd_prod   = 45'(wd_x) * 45'(RCP_7);
        q400_prod = 44'(r2_day) * 44'(RCP_400Y);
    end
    logic [16:0] r3_sod;
    logic [21:0] r3_day;
    logic [18:0] r3_wq;
    logic [4:0]  r3_q400;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_sod  <= {sod_hi, r2_tl[6:0]};
            r3_day  <= r2_day;
            r3_wq   <= wd_prod[43:25];
            r3_q400 <= q400_prod[43:39];
        end
    end

    // ---- stage 4: hour, weekday, day within 400-year cycle ---------------------
    logic [35:0] hr_prod;
    logic [2:0]  n_wd;
    logic [21:0] r400_full;
    always_comb begin
        hr_prod   = 36'(r3_sod) * 36'(RCP_3600);
        n_wd      = r3_day[2:0] + 3'd6 - r3_wq[2:0] * 3'd7;    // result < 7, mod 8 is exact
        r400_full = r3_day - 22'(r3_q400) * 22'(DAYS_400Y);
    end
    logic [4:0]  r4_hr;
    logic [16:0] r4_sod;
    logic [2:0]  r4_wd;
    logic [17:0] r4_r400;
    logic [13:0] r4_yr;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_hr   <= hr_prod[34:30];
            r4_sod  <= r3_sod;
            r4_wd   <= n_wd;
            r4_r400 <= r400_full[17:0];
            r4_yr   <= 14'(r3_q400) * 14'd400;
        end
    end

    // ---- stage 5: seconds of hour, century ------------------------------------
    // first century of a 400-year cycle has one extra day
    logic [16:0] ms_full;
    logic [1:0]  c100;
    logic [17:0] cbase;
    always_comb begin
        ms_full = r4_sod - 17'(r4_hr) * 17'd3600;
        if (r4_r400 >= CENT3) begin
            c100 = 2'd3; cbase = CENT3;
        end else if (r4_r400 >= CENT2) begin
            c100 = 2'd2; cbase = CENT2;
        end else if (r4_r400 >= CENT1) begin
            c100 = 2'd1; cbase = CENT1;
        end else begin
            c100 = 2'd0; cbase = 18'd0;
        end
    end
    logic [11:0] r5_ms;
    logic [4:0]  r5_hr;
    logic [2:0]  r5_wd;
    logic [16:0] r5_n100;
    logic        r5_nl;         // non-leap century
    logic [13:0] r5_yr;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_ms   <= ms_full[11:0];
            r5_hr   <= r4_hr;
            r5_wd   <= r4_wd;
            r5_n100 <= 17'(r4_r400 - cbase);
            r5_nl   <= (c100 != 2'd0);
            r5_yr   <= r4_yr + 14'(c100) * 14'd100;
        end
    end

    // ---- stage 6: minute, 4-year block -----------------------------------------
    // non-leap century: first 4-year block is one day short, so shift past it
    logic [24:0] mn_prod;
    logic [16:0] x4;
    logic [32:0] c4_prod;
    always_comb begin
        mn_prod = 25'(r5_ms) * 25'(RCP_60);
        x4 = r5_n100 + ((r5_nl && r5_n100 >= 17'(DAYS_4Y - 1)) ? 17'd1 : 17'd0);
        c4_prod = 33'(x4) * 33'(RCP_1461);
    end
    logic [5:0]  r6_mn;
    logic [11:0] r6_ms;
    logic [4:0]  r6_hr;
    logic [2:0]  r6_wd;
    logic [16:0] r6_x4;
    logic [4:0]  r6_c4;
    logic        r6_nl;
    logic [13:0] r6_yr;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_mn <= mn_prod[23:18];
            r6_ms <= r5_ms;
            r6_hr <= r5_hr;
            r6_wd <= r5_wd;
            r6_x4 <= x4;
            r6_c4 <= c4_prod[30:26];
            r6_nl <= r5_nl;
            r6_yr <= r5_yr;
        end
    end

    // ---- stage 7: second, day within 4-year block ------------------------------
    logic [11:0] sc_full;
    logic [16:0] n4_full;
    always_comb begin
        sc_full = r6_ms - 12'(r6_mn) * 12'd60;
        n4_full = r6_x4 - 17'(r6_c4) * 17'(DAYS_4Y);
    end
    logic [4:0]  r7_hr;
    logic [5:0]  r7_mn, r7_sc;
    logic [2:0]  r7_wd;
    logic [10:0] r7_n4;
    logic        r7_nl4;        // first 4-year block of a non-leap century
    logic [13:0] r7_yr;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_hr  <= r6_hr; r7_mn <= r6_mn; r7_sc <= sc_full[5:0]; r7_wd <= r6_wd;
            r7_n4  <= n4_full[10:0];
            r7_nl4 <= r6_nl && r6_c4 == 5'd0;
            r7_yr  <= r6_yr + 14'(r6_c4) * 14'd4;
        end
    end

    // ---- stage 8: single years -------------------------------------------------
    // non-leap first block: 365*4 days, else 366+365*3
    logic [10:0] yoff, yb1, yb2, yb3, ybase;
    logic [1:0]  c1;
    logic        lp;
    always_comb begin
        yoff = r7_nl4 ? 11'd0 : 11'd1;
        yb1  = 11'd365 + yoff;
        yb2  = 11'd730 + yoff;
        yb3  = 11'd1095 + yoff;
        if (r7_n4 >= yb3) begin
            c1 = 2'd3; ybase = yb3;
        end else if (r7_n4 >= yb2) begin
            c1 = 2'd2; ybase = yb2;
        end else if (r7_n4 >= yb1) begin
            c1 = 2'd1; ybase = yb1;
        end else begin
            c1 = 2'd0; ybase = 11'd0;
        end
        lp = !r7_nl4 && c1 == 2'd0;
    end
    logic [13:0] r8_yr; logic [8:0] r8_n; logic r8_lp;
    logic [4:0]  r8_hr; logic [5:0] r8_mn, r8_sc; logic [2:0] r8_wd;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_yr <= r7_yr + 14'(c1); r8_n <= 9'(r7_n4 - ybase); r8_lp <= lp;
            r8_hr <= r7_hr; r8_mn <= r7_mn; r8_sc <= r7_sc; r8_wd <= r7_wd;
        end
    end

    // ---- stage 9: month walk (compare against start table) -------------------
    logic [3:0] mi;
    logic [8:0] mstart;
    always_comb begin
        mi = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r8_n >= month_start(4'(k)) + ((k >= 2 && r8_lp) ? 9'd1 : 9'd0))
                mi = 4'(k);
        end
        mstart = month_start(mi) + ((mi >= 4'd2 && r8_lp) ? 9'd1 : 9'd0);
    end
    t_cal r9;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r9.year <= r8_yr; r9.month <= mi + 4'd1;
            r9.day_of_month <= 5'(r8_n - mstart) + 5'd1;
            r9.hour <= r8_hr; r9.minute <= r8_mn; r9.second <= r8_sc;
            r9.weekday <= r8_wd; r9.day_of_year <= r8_n;
        end
    end

    assign o_out.valid = r_vld[NST-1];
    assign o_out.data  = r9;

    // ---- checks ---------------------------------------------------------------
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(o_out.data)) else $error("out changed");
    a_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.month >= 4'd1 && o_out.data.month <= 4'd12)
        else $error("bad month");
    a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.hour < 5'd24 && o_out.data.minute < 6'd60)
        else $error("bad time");
endmodule

FILE: bench/us2cal_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// us2cal_checker
// Watches both channels of the converter, predicts each calendar word from
// the accepted seconds word and compares field by field, in order.
// ----------------------------------------------------------------------------
module us2cal_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic [us2cal_pkg::IN_W-1:0] i_in_data,
    input logic i_out_valid,
    input logic i_out_ready,
    input us2cal_pkg::t_cal i_out_data,
    output int  o_errors,
    output int  o_pending
);
    import us2cal_pkg::*;

    t_cal dates_due[$];
    int   err_cnt = 0;

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic t_cal civil_date(input logic [IN_W-1:0] raw);
        t_cal c;
        longint s;
        longint unsigned t;
        int unsigned n, y, m, h;
        s = longint'(signed'(raw));
        if (s < longint'(SECS_LOW)) s = longint'(SECS_LOW);
        if (s > longint'(SECS_HIGH)) s = longint'(SECS_HIGH);
        t = s - longint'(SECS_LOW);
        n = 32'(t / 86400);
        c.hour    = 5'((t / 3600) % 24);
        c.minute  = 6'((t / 60) % 60);
        c.second  = 6'(t % 60);
        c.weekday = 3'((n + 6) % 7);
        y = 400 * (n / DAYS_400Y);
        n = n % DAYS_400Y;
        forever begin
            h = DAYS_100Y + (leap_year(y) ? 1 : 0);
            if (n < h) break;
            n -= h; y += 100;
        end
        forever begin
            h = DAYS_4Y - (leap_year(y) ? 0 : 1);
            if (n < h) break;
            n -= h; y += 4;
        end
        forever begin
            h = DAYS_1Y + (leap_year(y) ? 1 : 0);
            if (n < h) break;
            n -= h; y += 1;
        end
        c.year = 14'(y);
        c.day_of_year = 9'(n);
        m = 0;
        while (m < 11) begin
            case (m)
                1: h = leap_year(y) ? 29 : 28;
                3, 5, 8, 10: h = 30;
                default: h = 31;
            endcase
            if (n < h) break;
            n -= h; m++;
        end
        c.month = 4'(m + 1);
        c.day_of_month = 5'(n + 1);
        return c;
    endfunction

    task automatic cmp(input string f, input int e, input int a);
        if (e != a) begin
            $display("%0t: %s mismatch expected %0d actual %0d", $realtime, f, e, a);
            err_cnt++;
        end
    endtask

    assign o_errors  = err_cnt;
    assign o_pending = dates_due.size();

    always @(posedge i_clk) begin
        t_cal e;
        if (i_rst_n && i_in_valid && i_in_ready)
            dates_due.push_back(civil_date(i_in_data));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (dates_due.size() == 0) begin
                $display("%0t: unexpected word expected none actual %h",
                    $realtime, i_out_data);
                err_cnt++;
            end else begin
                e = dates_due.pop_front();
                cmp("year", e.year, i_out_data.year);
                cmp("month", e.month, i_out_data.month);
                cmp("day_of_month", e.day_of_month, i_out_data.day_of_month);
                cmp("hour", e.hour, i_out_data.hour);
                cmp("minute", e.minute, i_out_data.minute);
                cmp("second", e.second, i_out_data.second);
                cmp("weekday", e.weekday, i_out_data.weekday);
                cmp("day_of_year", e.day_of_year, i_out_data.day_of_year);
            end
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives seconds words into the converter under several idling phases and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import us2cal_pkg::*;

    logic i_clk;
    logic i_rst_n;

    us2cal_if #(.T(logic [IN_W-1:0])) in_ch ();
    us2cal_if #(.T(t_cal))            out_ch ();

    int  n_errors, n_pending;
    int  send_idle, recv_stall;   // percent per phase
    bit  hold_off;                // long receiver hold-off
    int  hold_cnt;

    unix_seconds_to_calendar_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    us2cal_checker CHK (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_in_ready (in_ch.ready),
        .i_in_data  (in_ch.data),
        .i_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_out_data (out_ch.data),
        .o_errors   (n_errors),
        .o_pending  (n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard time limit: ~1650 words, with idling and stalls
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stall per phase, or a counted long hold-off
    initial begin
        out_ch.ready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= 200) begin
                    hold_off = 1'b0;
                    hold_cnt = 0;
                end
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // offer one word; valid stays high across back-to-back words
    task automatic send_word(input logic [IN_W-1:0] w);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk iff in_ch.ready);
        @(negedge i_clk);
    endtask

    // random seconds: mostly in range, some beyond both bounds, some raw bits
    function automatic logic [IN_W-1:0] rand_secs();
        longint v;
        int k;
        k = $urandom_range(99);
        if (k < 70) begin
            v = longint'(SECS_LOW) + (({$urandom, $urandom} & 64'h3F_FFFF_FFFF)
                % (longint'(SECS_HIGH) - longint'(SECS_LOW) + 1));
        end else if (k < 80) begin
            // near a year boundary: a whole number of mean Gregorian years after year 0
            v = longint'(SECS_LOW) + longint'($urandom_range(9999)) * 31556952
                + $urandom_range(200000) - 100000;
        end else if (k < 88) begin
            v = longint'(SECS_HIGH) - 50 + $urandom_range(100);
        end else if (k < 94) begin
            v = longint'(SECS_LOW) - 50 + $urandom_range(100);
        end else begin
            v = {$urandom, $urandom};
        end
        return v[IN_W-1:0];
    endfunction

    initial begin
        longint directed[$];
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, saturation on both sides, epoch, leap and century days
        directed = '{0, -1, 1, 86399, 86400,
            -64'sd62167219200, -64'sd62167219201, 64'sd253402300799, 64'sd253402300800,
            -64'sd274877906944, 64'sd274877906943,
            951782400,          // 2000-02-29
            951868800,          // 2000-03-01
            64'sd4107456000,    // 2100-02-28
            64'sd4107542400,    // 2100-03-01
            978220800,          // 2000-12-31 (day 365)
            1078099199,         // 2004-02-29 23:59:59
            -64'sd2208988800,   // 1900-01-01
            -64'sd62162035200,  // year 0 leap day vicinity
            946684799, 946684800, 1234567890, -1234567890};
        foreach (directed[i]) send_word(directed[i][IN_W-1:0]);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 54; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 54; end
                default: begin send_idle = 23; recv_stall = 23; end
            endcase
            for (int i = 0; i < 400; i++) begin
                // pressure: receiver holds off while sender keeps pushing
                if (ph == 0 && i == 100) hold_off = 1'b1;
                // sender pauses until everything has drained
                if (ph == 1 && i == 200) begin
                    in_ch.valid <= 1'b0;
                    while (n_pending != 0) @(negedge i_clk);
                end
                send_word(rand_secs());
            end
        end
        in_ch.valid <= 1'b0;
        recv_stall = 0;

        while (n_pending != 0 || hold_off) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (n_errors == 0 && n_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
